// ----- rtl/core/lfu_slot_replacement_assert.svh -----
// Assertion macros for the LFU slot replacement block.
// Included by the top level; needs no package.
`ifndef LFU_SLOT_REPLACEMENT_ASSERT_SVH
`define LFU_SLOT_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/lfu_sr_pkg.sv -----
// Types and fixed constants for the LFU slot replacement block.
// No dependencies.
`default_nettype none

package lfu_sr_pkg;

    localparam int ID_W        = 8;
    localparam int COUNT_W     = 16;
    localparam int AGE_W       = 5;
    localparam int SLOT_W      = 5;
    localparam int FRAMES_W    = 6;
    localparam int OUT_DATA_W  = 32;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET  = 6'd20;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 16'hFFFF;
    localparam logic [COUNT_W-1:0]  COUNT_ONE     = 16'd1;
    localparam logic [COUNT_W-1:0]  MAX_CANDIDATE = 16'd255;
    localparam logic [ID_W-1:0]     ID_EMPTY      = 8'd0;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_PICK  = 5'b00100,
        ST_EVICT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_after;
        logic [ID_W-1:0]    evicted_id;
        logic               evicted;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/lfu_slot_replacement.sv -----
// LFU slot replacement: sequencer over a slot table held in flops.
// Depends on lfu_sr_pkg and lfu_slot_replacement_assert.svh.
// Beat path: IDLE, SCAN, DONE for a hit or fill; IDLE, SCAN, PICK, EVICT, DONE for an
// eviction (SCAN and PICK walk lim = active slots); IDLE, DONE for a reserved id. The
// next beat is taken back in IDLE. Scan and minimum search share one slot read port.
// Reset (rst_n low, async): all slots empty, occupancy 0, frames_in_use 20, no clearing pass.
`default_nettype none

`include "lfu_slot_replacement_assert.svh"

module lfu_slot_replacement
    import lfu_sr_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [FRAMES_W-1:0]   cfg_wdata,    // frames_in_use
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [ID_W-1:0]       s_tdata,      // [7:0] candidate_id
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [4:0] slot, [5] hit, [6] evicted, [14:7] evicted_id, [30:15] count_after, [31] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIM_W = $clog2(SLOTS + 1);

    state_t                state_reg, state_next;
    logic [FRAMES_W-1:0]   frames_reg;
    logic [LIM_W-1:0]      occ_reg, occ_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [COUNT_W-1:0]    best_cnt_reg, best_cnt_next;
    logic [AGE_W-1:0]      best_age_reg, best_age_next;
    logic [ID_W-1:0]       best_cand_reg, best_cand_next;
    result_t               res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               m_data_reg, m_data_next;

    logic [ID_W-1:0]       cand_reg [SLOTS];
    logic [COUNT_W-1:0]    cnt_reg  [SLOTS];
    logic [AGE_W-1:0]      age_reg  [SLOTS];

    logic [LIM_W-1:0]      lim;
    logic [IDX_W-1:0]      last_idx;
    logic [ID_W-1:0]       rd_cand;
    logic [COUNT_W-1:0]    rd_cnt;
    logic [AGE_W-1:0]      rd_age;
    logic                  better;

    logic                  cand_we, cnt_we, age_we, age_dec;
    logic [IDX_W-1:0]      wr_idx;
    logic [COUNT_W-1:0]    wr_cnt;
    logic [AGE_W-1:0]      wr_age;

    // Active slot count, clamped to 1 .. SLOTS
    always_comb
    begin
        if (frames_reg == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (32'(frames_reg) > SLOTS)
        begin
            lim = LIM_W'(SLOTS);
        end
        else
        begin
            lim = LIM_W'(frames_reg);
        end
        last_idx = IDX_W'(lim - LIM_W'(1));
    end

    assign rd_cand = cand_reg[idx_reg];
    assign rd_cnt  = cnt_reg[idx_reg];
    assign rd_age  = age_reg[idx_reg];

    // Comparator for the minimum search: lower count wins, older rank breaks a tie
    assign better = (idx_reg == '0) || (rd_cnt < best_cnt_reg) ||
                    ((rd_cnt == best_cnt_reg) && (rd_age < best_age_reg));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_data_reg);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        id_next        = id_reg;
        best_idx_next  = best_idx_reg;
        best_cnt_next  = best_cnt_reg;
        best_age_next  = best_age_reg;
        best_cand_next = best_cand_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        cand_we        = 1'b0;
        cnt_we         = 1'b0;
        age_we         = 1'b0;
        age_dec        = 1'b0;
        wr_idx         = idx_reg;
        wr_cnt         = COUNT_ONE;
        wr_age         = AGE_W'(occ_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next  = s_tdata;
                    idx_next = '0;
                    res_next = '0;
                    if ((s_tdata == ID_EMPTY) || ({8'd0, s_tdata} > MAX_CANDIDATE))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_cand == ID_EMPTY)
                begin
                    cand_we              = 1'b1;
                    cnt_we               = 1'b1;
                    age_we               = 1'b1;
                    occ_next             = occ_reg + LIM_W'(1);
                    res_next.slot        = SLOT_W'(idx_reg);
                    res_next.count_after = COUNT_ONE;
                    state_next           = ST_DONE;
                end
                else if (rd_cand == id_reg)
                begin
                    cnt_we               = 1'b1;
                    wr_cnt               = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_ONE;
                    res_next.slot        = SLOT_W'(idx_reg);
                    res_next.hit         = 1'b1;
                    res_next.count_after = wr_cnt;
                    state_next           = ST_DONE;
                end
                else if (idx_reg == last_idx)
                begin
                    idx_next   = '0;
                    state_next = ST_PICK;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_PICK:
            begin
                if (better)
                begin
                    best_idx_next  = idx_reg;
                    best_cnt_next  = rd_cnt;
                    best_age_next  = rd_age;
                    best_cand_next = rd_cand;
                end
                if (idx_reg == last_idx)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_EVICT:
            begin
                // all younger slots close the gap; the victim becomes youngest
                age_dec              = 1'b1;
                cand_we              = 1'b1;
                cnt_we               = 1'b1;
                age_we               = 1'b1;
                wr_idx               = best_idx_reg;
                wr_age               = AGE_W'(occ_reg - LIM_W'(1));
                res_next.slot        = SLOT_W'(best_idx_reg);
                res_next.evicted     = 1'b1;
                res_next.evicted_id  = best_cand_reg;
                res_next.count_after = COUNT_ONE;
                state_next           = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            frames_reg  <= FRAMES_RESET;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                frames_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        id_reg        <= id_next;
        best_idx_reg  <= best_idx_next;
        best_cnt_reg  <= best_cnt_next;
        best_age_reg  <= best_age_next;
        best_cand_reg <= best_cand_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                cand_reg[j] <= ID_EMPTY;
            end
        end
        else if (cand_we)
        begin
            cand_reg[wr_idx] <= id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_reg[wr_idx] <= wr_cnt;
        end
        for (int j = 0; j < SLOTS; j++)
        begin
            if (age_we && (wr_idx == IDX_W'(j)))
            begin
                age_reg[j] <= wr_age;
            end
            else if (age_dec && (cand_reg[j] != ID_EMPTY) && (age_reg[j] > best_age_reg))
            begin
                age_reg[j] <= age_reg[j] - AGE_W'(1);
            end
        end
    end

    `LFU_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input taken while an item is still in work")
    `LFU_ASSERT_NOW(a_hit_not_evict, clk, rst_n, m_tvalid, !(m_tdata[5] && m_tdata[6]),
        "result flags both hit and eviction")
    `LFU_ASSERT_NOW(a_evict_fields, clk, rst_n, m_tvalid && m_tdata[6],
        (m_tdata[14:7] != ID_EMPTY) && (m_tdata[30:15] == COUNT_ONE),
        "eviction result with empty victim or count not restarted")
    `LFU_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, 32'(occ_reg) <= SLOTS,
        "occupancy above slot count")

endmodule

`default_nettype wire

// ----- dv/lfu_slot_replacement_test.sv -----
// Self-checking bench for lfu_slot_replacement: directed cases, then random reference streams.
// A cycle-free model of the slot table predicts each result beat.
// Depends on lfu_sr_pkg and the RTL of the block.
`timescale 1ns / 100ps

module lfu_slot_replacement_test;
    import lfu_sr_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;

    typedef struct {
        logic [ID_W-1:0] id;
        result_t         res;
    } ref_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [FRAMES_W-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [ID_W-1:0]       s_tdata;     // [7:0] candidate_id
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [4:0] slot, [5] hit, [6] evicted, [14:7] evicted_id, [30:15] count_after, [31] zero
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow of the slot table
    logic [ID_W-1:0]     tbl_id  [TABLE_DEPTH];
    logic [COUNT_W-1:0]  tbl_cnt [TABLE_DEPTH];
    logic [AGE_W-1:0]    tbl_age [TABLE_DEPTH];
    int unsigned         tbl_used;
    logic [FRAMES_W-1:0] frames_reg;

    ref_outcome_t refs_awaiting[$];
    int           mismatches = 0;
    bit           steady = 1'b0;     // no idling on either side while set

    lfu_slot_replacement #(
        .SLOTS (TABLE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int active_slots();
        if (frames_reg == 0)
            return 1;
        if (frames_reg > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(frames_reg);
    endfunction

    // Updates the shadow table for one reference and returns the result beat it causes.
    function automatic result_t lfu_predict(input logic [ID_W-1:0] id);
        result_t        r;
        int             lim;
        int             j;
        int             victim;
        logic [AGE_W-1:0] old_rank;
        r = '0;
        if (id == ID_EMPTY || COUNT_W'(id) > MAX_CANDIDATE)
            return r;
        lim = active_slots();
        for (j = 0; j < lim; j++)
        begin
            if (tbl_id[j] == ID_EMPTY)
            begin
                tbl_id[j]  = id;
                tbl_cnt[j] = COUNT_ONE;
                tbl_age[j] = AGE_W'(tbl_used);
                tbl_used++;
                r.slot        = SLOT_W'(j);
                r.count_after = COUNT_ONE;
                return r;
            end
            if (tbl_id[j] == id)
            begin
                if (tbl_cnt[j] != COUNT_MAX)
                    tbl_cnt[j]++;
                r.slot        = SLOT_W'(j);
                r.hit         = 1'b1;
                r.count_after = tbl_cnt[j];
                return r;
            end
        end
        // all active slots taken: lowest count, oldest first on a tie
        victim = 0;
        for (j = 1; j < lim; j++)
            if (tbl_cnt[j] < tbl_cnt[victim] ||
                (tbl_cnt[j] == tbl_cnt[victim] && tbl_age[j] < tbl_age[victim]))
                victim = j;
        old_rank = tbl_age[victim];
        // ranks close up over every occupied slot, active or not
        for (j = 0; j < TABLE_DEPTH; j++)
            if (tbl_id[j] != ID_EMPTY && tbl_age[j] > old_rank)
                tbl_age[j]--;
        r.slot        = SLOT_W'(victim);
        r.evicted     = 1'b1;
        r.evicted_id  = tbl_id[victim];
        r.count_after = COUNT_ONE;
        tbl_age[victim] = AGE_W'(tbl_used - 1);
        tbl_id[victim]  = id;
        tbl_cnt[victim] = COUNT_ONE;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input int id, input int got, input int want);
        mismatches++;
        if (mismatches <= 60)
            $display("%0t mismatch on %s for id %0d: got %0d, want %0d",
                     $realtime, field, id, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t      got;
        ref_outcome_t exp_item;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[OUT_DATA_W-2:0]);
            if (refs_awaiting.size() == 0)
                flag_mismatch("unexpected beat", -1, int'(m_tdata), 0);
            else
            begin
                exp_item = refs_awaiting.pop_front();
                if (got.slot !== exp_item.res.slot)
                    flag_mismatch("slot", int'(exp_item.id), int'(got.slot),
                                  int'(exp_item.res.slot));
                if (got.hit !== exp_item.res.hit)
                    flag_mismatch("hit", int'(exp_item.id), int'(got.hit),
                                  int'(exp_item.res.hit));
                if (got.evicted !== exp_item.res.evicted)
                    flag_mismatch("evicted", int'(exp_item.id), int'(got.evicted),
                                  int'(exp_item.res.evicted));
                if (got.evicted_id !== exp_item.res.evicted_id)
                    flag_mismatch("evicted_id", int'(exp_item.id), int'(got.evicted_id),
                                  int'(exp_item.res.evicted_id));
                if (got.count_after !== exp_item.res.count_after)
                    flag_mismatch("count_after", int'(exp_item.id), int'(got.count_after),
                                  int'(exp_item.res.count_after));
                if (m_tdata[OUT_DATA_W-1] !== 1'b0)
                    flag_mismatch("pad bit", int'(exp_item.id), int'(m_tdata[OUT_DATA_W-1]), 0);
            end
        end
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 35);

    // Leaves s_tvalid high on return so back-to-back beats need no second assignment.
    task automatic reference_id(input logic [ID_W-1:0] id);
        ref_outcome_t item;
        while (!steady && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= id;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        item.id  = id;
        item.res = lfu_predict(id);
        refs_awaiting.insert(refs_awaiting.size(), item);
    endtask

    task automatic wait_empty();
        while (refs_awaiting.size() != 0)
            @(posedge clk);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frames(input logic [FRAMES_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        frames_reg = value;
        @(posedge clk);
    endtask

    // reserved id, both ends of the id range, hit on the top id
    task automatic test_reserved_ids();
        reference_id(ID_EMPTY);
        reference_id(8'd255);
        reference_id(8'd1);
        reference_id(ID_EMPTY);
        reference_id(8'd255);
        reference_id(8'd170);
        quiesce();
    endtask

    // hits, lowest-count eviction and the oldest-first tie break in three slots
    task automatic test_fill_hit_evict();
        set_frames(6'd3);
        reference_id(8'd85);        // window full: two slots tie on count, oldest goes
        reference_id(8'd255);
        reference_id(8'd1);         // tie again between the two single-count slots
        reference_id(8'd40);        // evicts lowest count
        reference_id(8'd40);
        reference_id(8'd85);        // lowest count goes
        reference_id(8'd50);
        quiesce();
    endtask

    // register values below and above the legal range
    task automatic test_frame_clamp();
        set_frames(6'd0);
        reference_id(8'd3);
        reference_id(8'd4);
        quiesce();
        set_frames(6'd63);
        reference_id(8'd200);
        reference_id(8'd201);
        quiesce();
    endtask

    // slots past a lowered limit keep their ids but are neither found nor replaced
    task automatic test_shrunk_window();
        int k;
        set_frames(6'd6);
        for (k = 0; k < 3; k++)
            reference_id(8'(110 + k));
        quiesce();
        set_frames(6'd2);
        reference_id(8'd201);       // held outside the window now
        reference_id(8'd3);
        quiesce();
        set_frames(6'd6);
        reference_id(8'd201);
        reference_id(8'd112);
        quiesce();
    endtask

    // single active slot hammered back to back so its count climbs
    task automatic test_hot_count();
        int k;
        set_frames(6'd1);
        steady = 1'b1;
        for (k = 0; k < 24; k++)
            reference_id(8'd77);
        quiesce();
        steady = 1'b0;
    endtask

    task automatic test_random_streams();
        logic [FRAMES_W-1:0] frame_plan [12];
        logic [ID_W-1:0]     base;
        logic [ID_W-1:0]     id;
        int                  phase;
        int                  k;
        int                  span;
        int                  pick;
        frame_plan = '{6'd2, 6'd5, 6'd32, 6'd1, 6'd12, 6'd0,
                       6'd40, 6'd20, 6'd3, 6'd63, 6'd8, 6'd32};
        for (phase = 0; phase < 12; phase++)
        begin
            set_frames(frame_plan[phase]);
            span   = active_slots();
            base   = 8'($urandom_range(1, 255 - 36));
            steady = (phase == 2);
            for (k = 0; k < 50; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    id = ID_EMPTY;
                else if (pick < 13)
                    id = 8'($urandom_range(1, 255));
                else if (pick < 55)
                    id = base + 8'($urandom_range(0, 2));   // hot ids build up counts
                else
                    id = base + 8'($urandom_range(0, span + 2));
                reference_id(id);
                if (k == 25)
                begin
                    s_tvalid <= 1'b0;
                    wait_empty();
                end
            end
            quiesce();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int guard;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            tbl_id[j]  = ID_EMPTY;
            tbl_cnt[j] = '0;
            tbl_age[j] = '0;
        end
        tbl_used   = 0;
        frames_reg = FRAMES_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reserved_ids();
        test_fill_hit_evict();
        test_frame_clamp();
        test_shrunk_window();
        test_hot_count();
        test_random_streams();

        s_tvalid <= 1'b0;
        guard = 0;
        while (refs_awaiting.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (refs_awaiting.size() != 0)
            flag_mismatch("beats never returned", -1, 0, refs_awaiting.size());
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lfu_sr_pkg.sv
rtl/core/lfu_slot_replacement.sv
dv/lfu_slot_replacement_test.sv
